FILE: design/multi_axis_step_scheduler_unit_defines.svh
// Assertion macros used by the scheduler unit.
`ifndef MULTI_AXIS_STEP_SCHEDULER_UNIT_DEFINES_SVH
`define MULTI_AXIS_STEP_SCHEDULER_UNIT_DEFINES_SVH
// Property that holds after reset.
`define MASS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Property checked during reset as well.
`define MASS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`endif

FILE: design/mass_pkg.sv
// ----------------------------------------------------------------------------
// mass_pkg
// Shared types and constants of the multi-axis step scheduler.
// ----------------------------------------------------------------------------
package mass_pkg;
   localparam int AXES = 5;
   localparam int STEPPERS = 3;
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_MOVE  = 3'd1;
   localparam logic [2:0] KIND_GO    = 3'd2;
   localparam logic [2:0] KIND_STOP  = 3'd3;
   localparam logic [2:0] KIND_LOAD  = 3'd4;
   localparam logic [2:0] KIND_QUERY = 3'd5;
   localparam logic CSR_MAX_RATE = 1'b0;
   localparam logic CSR_CLOCK_HZ = 1'b1;
   localparam logic [15:0] MAX_RATE_RESET = 16'd1000;
   localparam logic [15:0] CLOCK_HZ_RESET = 16'd20000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  motor;
      logic [15:0] rate;
      logic [15:0] direction;
      logic [15:0] step_count;
      logic [15:0] target;
      logic [15:0] low_limit;
      logic [15:0] high_limit;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  turret_coils;
      logic [3:0]  arm_coils;
      logic [3:0]  boom_coils;
      logic [15:0] rotate_compare;
      logic [15:0] grip_compare;
      logic [15:0] query_rate;
      logic [1:0]  query_direction;
      logic [15:0] query_position;
      logic [15:0] query_low;
      logic [15:0] query_high;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [15:0] quotient;
   } div_stat_type;

   function automatic logic [3:0] coil_pattern(input logic rev, input logic [1:0] ph);
      logic [3:0] p;
      case (ph)
         2'd0: p = 4'h9;
         2'd1: p = 4'ha;
         2'd2: p = 4'h6;
         default: p = 4'h5;
      endcase
      if (rev) begin
         case (ph)
            2'd0: p = 4'h5;
            2'd1: p = 4'h6;
            2'd2: p = 4'ha;
            default: p = 4'h9;
         endcase
      end
      return p;
   endfunction
endpackage

FILE: design/mass_stream_if.sv
// ----------------------------------------------------------------------------
// mass_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface mass_stream_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/multi_axis_step_scheduler_unit.sv
// ----------------------------------------------------------------------------
// multi_axis_step_scheduler_unit
// Five-axis step scheduler: three steppers and two servos under commands.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | kind, motor, rate, direction, step_count, target, limits
// rsp     | out | status, coil nibbles, servo compares, query fields
// csr     | in  | write enable, index, 16-bit data
//
// Commands other than tick go from idle straight to the done state. A tick walks
// the five axes in turn; an axis that reloads runs the shared divider before the
// walk moves on to the next axis.
// Reset clears all axis state; no clearing pass is needed.
// req is ready only in the done state, so a request is taken as its result is
// written; a stalled rsp holds the result and keeps the next request waiting.
// ----------------------------------------------------------------------------
`include "multi_axis_step_scheduler_unit_defines.svh"
module multi_axis_step_scheduler_unit #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   mass_stream_if.sink   req,
   mass_stream_if.source rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   localparam int PB = POSITION_BITS;
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_AXIS = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;

   mass_pkg::req_type cmd;
   mass_pkg::rsp_type rsp_ff, rsp_in;
   assign cmd = mass_pkg::req_type'(req.data);

   logic [15:0] max_rate_ff, clk_hz_ff;
   logic [15:0] rate_ff [mass_pkg::AXES];
   logic [15:0] cd_ff [mass_pkg::AXES];
   logic [1:0]  dir_ff [mass_pkg::AXES];
   logic [15:0] steps_ff [mass_pkg::AXES];
   logic signed [PB-1:0] pos_ff [mass_pkg::AXES];
   logic signed [PB-1:0] low_ff [mass_pkg::AXES];
   logic signed [PB-1:0] high_ff [mass_pkg::AXES];
   logic [1:0]  phase_ff [mass_pkg::STEPPERS];
   logic [3:0]  coil_ff [mass_pkg::STEPPERS];
   logic [15:0] servo_ff [2];

   logic [2:0] state_ff, state_in;
   logic [2:0] ax_ff, ax_in;
   logic       rsp_valid_ff, rsp_valid_in;

   mass_pkg::div_req_type  div_req;
   mass_pkg::div_stat_type div_stat;
   mass_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_stat(div_stat));

   // decoded request fields
   logic [2:0] ax_sel;
   logic       bad;
   logic [15:0] rate_clamp;
   logic signed [PB-1:0] tgt_w, tgt_c, pos_sel;
   logic signed [PB:0] go_dist;
   logic [PB:0] dist_abs;
   logic [15:0] go_steps;
   assign ax_sel = cmd.motor[2:0];
   assign bad = (cmd.kind > mass_pkg::KIND_QUERY) ||
                ((cmd.kind != mass_pkg::KIND_TICK) && (cmd.kind != mass_pkg::KIND_STOP) &&
                 (cmd.motor >= 4'(mass_pkg::AXES)));
   assign rate_clamp = (cmd.rate > max_rate_ff) ? max_rate_ff : cmd.rate;
   assign pos_sel = pos_ff[ax_sel];
   always_comb begin
      tgt_w = PB'($signed(cmd.target));
      tgt_c = tgt_w;
      if (tgt_c > high_ff[ax_sel]) tgt_c = high_ff[ax_sel];
      if (tgt_c < low_ff[ax_sel]) tgt_c = low_ff[ax_sel];
      go_dist = {tgt_c[PB-1], tgt_c} - {pos_sel[PB-1], pos_sel};
      dist_abs = go_dist[PB] ? (PB+1)'(-go_dist) : go_dist;
      go_steps = (dist_abs > (PB+1)'(32767)) ? 16'd32767 : 16'(dist_abs);
   end

   // status error bit set in done state
   logic cmd_err;
   assign cmd_err = bad || ((cmd.kind == mass_pkg::KIND_MOVE) &&
                    (cmd.rate[15] || ($signed(cmd.step_count) < -16'sd1))) ||
                    ((cmd.kind == mass_pkg::KIND_GO) && cmd.rate[15]);

   // current tick axis
   logic signed [PB-1:0] apos;
   logic [1:0] adir;
   logic       a_hi, a_lo, a_stop;
   assign apos = pos_ff[ax_ff];
   assign adir = dir_ff[ax_ff];
   assign a_hi = apos > high_ff[ax_ff];
   assign a_lo = apos < low_ff[ax_ff];
   assign a_stop = a_hi || a_lo || (steps_ff[ax_ff] == 16'd0);

   always_comb begin
      state_in = state_ff; ax_in = ax_ff; rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      div_req.start = 1'b0;
      div_req.dividend = clk_hz_ff;
      div_req.divisor = (rate_ff[ax_ff] == 16'd0) ? 16'd1 : rate_ff[ax_ff];
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // start only with the result register empty
            if (req.valid && !rsp_valid_ff) begin
               if (!bad && cmd.kind == mass_pkg::KIND_TICK) begin
                  state_in = ST_AXIS; ax_in = '0;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_AXIS: begin
            if (adir != 2'd0 && cd_ff[ax_ff] == 16'd0 && !a_stop) begin
               div_req.start = 1'b1; state_in = ST_DIV;
            end else if (ax_ff == 3'(mass_pkg::AXES - 1)) begin
               state_in = ST_DONE;
            end else begin
               ax_in = ax_ff + 3'd1;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (ax_ff == 3'(mass_pkg::AXES - 1)) state_in = ST_DONE;
               else begin
                  ax_in = ax_ff + 3'd1; state_in = ST_AXIS;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE; rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.status = cmd_err;
            rsp_in.turret_coils = coil_ff[0];
            rsp_in.arm_coils = coil_ff[1];
            rsp_in.boom_coils = coil_ff[2];
            rsp_in.rotate_compare = servo_ff[0];
            rsp_in.grip_compare = servo_ff[1];
            if (!bad && cmd.kind == mass_pkg::KIND_QUERY) begin
               rsp_in.query_rate = rate_ff[ax_sel];
               rsp_in.query_direction = dir_ff[ax_sel];
               rsp_in.query_position = 16'(pos_ff[ax_sel]);
               rsp_in.query_low = 16'(low_ff[ax_sel]);
               rsp_in.query_high = 16'(high_ff[ax_sel]);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold the request on the port until the result is built
   assign req.ready = (state_ff == ST_DONE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE; ax_ff <= '0; rsp_valid_ff <= 1'b0;
         max_rate_ff <= mass_pkg::MAX_RATE_RESET; clk_hz_ff <= mass_pkg::CLOCK_HZ_RESET;
         for (int i = 0; i < mass_pkg::AXES; i++) begin
            rate_ff[i] <= '0; cd_ff[i] <= '0; dir_ff[i] <= '0; steps_ff[i] <= '0;
            pos_ff[i] <= '0; low_ff[i] <= '0; high_ff[i] <= '0;
         end
         for (int i = 0; i < mass_pkg::STEPPERS; i++) begin
            phase_ff[i] <= '0; coil_ff[i] <= mass_pkg::coil_pattern(i == 1, 2'd0);
         end
         servo_ff[0] <= '0; servo_ff[1] <= '0;
      end else begin
         state_ff <= state_in; ax_ff <= ax_in; rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == mass_pkg::CSR_MAX_RATE) max_rate_ff <= csr_data;
            else clk_hz_ff <= csr_data;
         end
         if (state_ff == ST_AXIS && adir != 2'd0) begin
            if (cd_ff[ax_ff] != 16'd0) begin
               cd_ff[ax_ff] <= cd_ff[ax_ff] - 16'd1;
            end else begin
               if (a_hi) pos_ff[ax_ff] <= high_ff[ax_ff];
               else if (a_lo) pos_ff[ax_ff] <= low_ff[ax_ff];
               if (a_stop) dir_ff[ax_ff] <= 2'd0;
               else begin
                  // advance coil or servo, step position, count down
                  if (ax_ff < 3'(mass_pkg::STEPPERS)) begin
                     phase_ff[ax_ff[1:0]] <= phase_ff[ax_ff[1:0]] + adir;
                     coil_ff[ax_ff[1:0]] <= mass_pkg::coil_pattern(ax_ff == 3'd1,
                        phase_ff[ax_ff[1:0]] + adir);
                  end else begin
                     servo_ff[~ax_ff[0]] <= 16'(apos);
                  end
                  pos_ff[ax_ff] <= apos + PB'($signed(adir));
                  if (!steps_ff[ax_ff][15]) steps_ff[ax_ff] <= steps_ff[ax_ff] - 16'd1;
               end
            end
         end
         if (state_ff == ST_DIV && div_stat.done) cd_ff[ax_ff] <= div_stat.quotient;
         if (state_ff == ST_DONE && !bad) begin
            case (cmd.kind)
               mass_pkg::KIND_MOVE: begin
                  if (!cmd.rate[15]) begin
                     rate_ff[ax_sel] <= rate_clamp;
                     if ($signed(cmd.step_count) >= -16'sd1) begin
                        steps_ff[ax_sel] <= cmd.step_count;
                        dir_ff[ax_sel] <= cmd.direction[15] ? 2'b11 :
                                          (cmd.direction != 16'd0 ? 2'b01 : 2'b00);
                     end
                  end
               end
               mass_pkg::KIND_GO: begin
                  if (!cmd.rate[15]) begin
                     rate_ff[ax_sel] <= rate_clamp;
                     steps_ff[ax_sel] <= go_steps;
                     dir_ff[ax_sel] <= go_dist[PB] ? 2'b11 :
                                       (go_dist != '0 ? 2'b01 : 2'b00);
                  end
               end
               mass_pkg::KIND_STOP: begin
                  for (int i = 0; i < mass_pkg::AXES; i++) dir_ff[i] <= 2'd0;
               end
               mass_pkg::KIND_LOAD: begin
                  pos_ff[ax_sel] <= PB'($signed(cmd.target));
                  low_ff[ax_sel] <= PB'($signed(cmd.low_limit));
                  high_ff[ax_sel] <= PB'($signed(cmd.high_limit));
               end
               default: ;
            endcase
         end
      end
   end

   `MASS_ASSERT(a_div_only_in_div, div_stat.busy |-> (state_ff == ST_DIV), "divider busy outside")
   `MASS_ASSERT(a_ready_idle, req.ready |-> (state_ff == ST_DONE), "ready outside done")
   `MASS_ASSERT(a_start_axis, div_req.start |=> (state_ff == ST_DIV), "start without div state")
endmodule

FILE: design/mass_divider.sv
// ----------------------------------------------------------------------------
// mass_divider
// Restoring 16-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mass_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  mass_pkg::div_req_type      div_req,
   output mass_pkg::div_stat_type     div_stat
);
   logic [15:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dsr_in = dsr_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[15]} - {1'b0, dsr_ff};
      if (div_req.start) begin
         rem_in = '0; quo_in = div_req.dividend; dsr_in = div_req.divisor;
         cnt_in = 5'd16; busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, keep the difference when it fits
         if (!trial[16]) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[14:0], quo_ff[15]};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign div_stat.quotient = quo_ff;
endmodule
